// ===== src/bfsp_pkg.sv =====
package bfsp_pkg;

   // Default sizes
   localparam int MAX_VERTICES_DEF = 64;
   localparam int MAX_EDGES_DEF    = 256;

   // Register reset value and field widths
   localparam logic [6:0] NUM_VERTICES_RESET = 7'd64;
   localparam int VERTEX_W = 7;
   localparam int WEIGHT_W = 16;
   localparam int DIST_W   = 32;

   // Saturation bounds of a distance
   localparam logic [DIST_W-1:0] INT_MAX = 32'h7FFF_FFFF;
   localparam logic [DIST_W-1:0] INT_MIN = 32'h8000_0000;

   // Result kinds
   localparam logic [2:0] KIND_ACCEPT   = 3'd0;
   localparam logic [2:0] KIND_REJECT   = 3'd1;
   localparam logic [2:0] KIND_DIST     = 3'd2;
   localparam logic [2:0] KIND_NEGCYC   = 3'd3;
   localparam logic [2:0] KIND_BADSTART = 3'd4;

   // Input function codes
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_RUN  = 1'b1;

   // One stored edge
   typedef struct packed {
      logic [VERTEX_W-1:0] src;
      logic [VERTEX_W-1:0] dst;
      logic [WEIGHT_W-1:0] weight;
   } edge_type;

endpackage

// ===== src/bfsp_if.sv =====
interface bfsp_req_if import bfsp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                func;
   logic [VERTEX_W-1:0] src_vertex;
   logic [VERTEX_W-1:0] dst_vertex;
   logic [WEIGHT_W-1:0] edge_weight;
   logic [VERTEX_W-1:0] start_vertex;

   modport source (output valid, func, src_vertex, dst_vertex, edge_weight, start_vertex,
                   input ready);
   modport sink   (input valid, func, src_vertex, dst_vertex, edge_weight, start_vertex,
                   output ready);
endinterface

interface bfsp_rsp_if import bfsp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [2:0]          kind;
   logic [VERTEX_W-1:0] vertex;
   logic [DIST_W-1:0]   distance;
   logic                reachable;
   logic                last;

   modport source (output valid, kind, vertex, distance, reachable, last, input ready);
   modport sink   (input valid, kind, vertex, distance, reachable, last, output ready);
endinterface

// ===== src/bfsp_ram.sv =====
module bfsp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== src/bellman_ford_shortest_paths_core.sv =====
// Single-source shortest paths over a loaded list of directed, weighted edges.
// Channel req takes one item at a time: func 0 loads an edge (src_vertex,
// dst_vertex, edge_weight), func 1 runs from start_vertex. Channel rsp gives
// the results: one accept or reject per load; per run either one bad-start or
// negative-cycle item, or one distance item for each vertex but the start,
// in vertex order, the final one flagged by last. csr_we/csr_wdata write the
// vertex count in use; write it only while the block is idle.
// A load scans the stored edges for a duplicate pair before it appends.
// A run makes passes over the stored edges: per edge an edge read, then, if
// the edge is used, a source distance read and a destination read and update
// through one shared adder/comparator, for at most num_vertices passes; the
// distance items follow, each with its own distance read.
// req.ready is high only between items. Results leave through an output
// register; a stalled receiver holds the sequencer at the next result, and
// the final result may wait there while the next item is accepted.
// Reset empties the edge table, marks all distances unreachable and sets the
// vertex count to 64. No clearing pass is needed.
module bellman_ford_shortest_paths_core import bfsp_pkg::*; #(
   parameter int MAX_VERTICES = MAX_VERTICES_DEF,
   parameter int MAX_EDGES    = MAX_EDGES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   bfsp_req_if.sink            req,
   bfsp_rsp_if.source          rsp,
   input  logic                csr_we,
   input  logic [VERTEX_W-1:0] csr_wdata
);

   localparam int VW  = $clog2(MAX_VERTICES);
   localparam int EAW = $clog2(MAX_EDGES);
   localparam int ECW = $clog2(MAX_EDGES + 1);

   typedef enum logic [9:0] {
      S_IDLE      = 10'b00_0000_0001,
      S_DECODE    = 10'b00_0000_0010,
      S_LD_SCAN   = 10'b00_0000_0100,
      S_LD_CMP    = 10'b00_0000_1000,
      S_RUN_EDGE  = 10'b00_0001_0000,
      S_RUN_FETCH = 10'b00_0010_0000,
      S_RUN_SRC   = 10'b00_0100_0000,
      S_RUN_DST   = 10'b00_1000_0000,
      S_OUT_READ  = 10'b01_0000_0000,
      S_OUT_LOAD  = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [VERTEX_W-1:0]     nv_ff, nv_in;
   logic [ECW-1:0]          count_ff, count_in;
   logic [ECW-1:0]          idx_ff, idx_in;
   logic [VERTEX_W-1:0]     pass_ff, pass_in;
   logic                    changed_ff, changed_in;
   logic [MAX_VERTICES-1:0] ok_ff, ok_in;
   logic [VERTEX_W-1:0]     vtx_ff, vtx_in;

   logic                    func_ff, func_in;
   edge_type                ld_ff, ld_in;
   logic [VERTEX_W-1:0]     start_ff, start_in;
   edge_type                edge_ff, edge_in;
   logic [DIST_W-1:0]       sum_ff, sum_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [2:0]              rsp_kind_ff, rsp_kind_in;
   logic [VERTEX_W-1:0]     rsp_vertex_ff, rsp_vertex_in;
   logic [DIST_W-1:0]       rsp_dist_ff, rsp_dist_in;
   logic                    rsp_reach_ff, rsp_reach_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic [VERTEX_W-1:0]     n_eff;
   logic                    rsp_free;
   logic                    ld_bad;
   logic                    start_bad;
   logic                    edge_use;
   logic                    out_last;
   logic [DIST_W:0]         sum_wide;

   edge_type                edge_rdata;
   logic                    edge_we;
   logic [DIST_W-1:0]       dist_rdata;
   logic                    dist_we;
   logic [VW-1:0]           dist_raddr;
   logic [VW-1:0]           dist_waddr;
   logic [DIST_W-1:0]       dist_wdata;

   // Effective vertex count, saturated into 2..MAX_VERTICES
   always_comb begin
      priority if (nv_ff < 7'd2) begin
         n_eff = 7'd2;
      end else if (32'(nv_ff) > 32'(MAX_VERTICES)) begin
         n_eff = VERTEX_W'(MAX_VERTICES);
      end else begin
         n_eff = nv_ff;
      end
   end

   assign rsp_free  = !rsp_valid_ff || rsp.ready;
   assign ld_bad    = (ld_ff.src == ld_ff.dst) || (ld_ff.src == '0) || (ld_ff.dst == '0)
                      || (ld_ff.src > n_eff) || (ld_ff.dst > n_eff)
                      || (count_ff == ECW'(MAX_EDGES));
   assign start_bad = (start_ff == '0) || (start_ff > n_eff);

   // Edge counts only when both ends are in range and the source is reached
   assign edge_use  = (edge_rdata.src != '0) && (edge_rdata.src <= n_eff)
                      && (edge_rdata.dst != '0) && (edge_rdata.dst <= n_eff)
                      && ok_ff[VW'(edge_rdata.src - 7'd1)];

   assign out_last  = (vtx_ff == n_eff) || ((vtx_ff == n_eff - 7'd1) && (start_ff == n_eff));

   // Shared adder: source distance plus weight, saturated to 32 bits
   assign sum_wide  = {dist_rdata[DIST_W-1], dist_rdata}
                      + {{(DIST_W + 1 - WEIGHT_W){edge_ff.weight[WEIGHT_W-1]}}, edge_ff.weight};
   always_comb begin
      priority if (sum_wide[DIST_W] != sum_wide[DIST_W-1]) begin
         sum_in = sum_wide[DIST_W] ? INT_MIN : INT_MAX;
      end else begin
         sum_in = sum_wide[DIST_W-1:0];
      end
   end

   // Distance read address follows the sequencer step
   always_comb begin
      unique case (state_ff)
         S_RUN_FETCH:           dist_raddr = VW'(edge_rdata.src - 7'd1);
         S_RUN_SRC:             dist_raddr = VW'(edge_ff.dst - 7'd1);
         S_OUT_READ, S_OUT_LOAD: dist_raddr = VW'(vtx_ff - 7'd1);
         default:               dist_raddr = VW'(vtx_ff - 7'd1);
      endcase
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      nv_in         = csr_we ? csr_wdata : nv_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      pass_in       = pass_ff;
      changed_in    = changed_ff;
      ok_in         = ok_ff;
      vtx_in        = vtx_ff;
      func_in       = func_ff;
      ld_in         = ld_ff;
      start_in      = start_ff;
      edge_in       = edge_ff;
      edge_we       = 1'b0;
      dist_we       = 1'b0;
      dist_waddr    = VW'(edge_ff.dst - 7'd1);
      dist_wdata    = sum_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_vertex_in = rsp_vertex_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_reach_in  = rsp_reach_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            // Latch the item
            if (req.valid) begin
               func_in   = req.func;
               ld_in     = '{src: req.src_vertex, dst: req.dst_vertex, weight: req.edge_weight};
               start_in  = req.start_vertex;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            idx_in = '0;
            if (func_ff == FUNC_LOAD) begin
               if (!ld_bad) begin
                  state_in = S_LD_SCAN;
               end else if (rsp_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = KIND_REJECT;
                  rsp_vertex_in = '0;
                  rsp_dist_in   = '0;
                  rsp_reach_in  = 1'b0;
                  rsp_last_in   = 1'b1;
                  state_in      = S_IDLE;
               end
            end else if (start_bad) begin
               if (rsp_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = KIND_BADSTART;
                  rsp_vertex_in = '0;
                  rsp_dist_in   = '0;
                  rsp_reach_in  = 1'b0;
                  rsp_last_in   = 1'b1;
                  state_in      = S_IDLE;
               end
            end else begin
               // Start a run: only the start is reached, at distance zero
               ok_in                          = '0;
               ok_in[VW'(start_ff - 7'd1)]    = 1'b1;
               dist_we                        = 1'b1;
               dist_waddr                     = VW'(start_ff - 7'd1);
               dist_wdata                     = '0;
               pass_in                        = 7'd1;
               changed_in                     = 1'b0;
               state_in                       = S_RUN_EDGE;
            end
         end
         S_LD_SCAN: begin
            // Scan for a duplicate pair, append when none
            if (idx_ff == count_ff) begin
               if (rsp_free) begin
                  edge_we       = 1'b1;
                  count_in      = count_ff + 1'b1;
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = KIND_ACCEPT;
                  rsp_vertex_in = '0;
                  rsp_dist_in   = '0;
                  rsp_reach_in  = 1'b0;
                  rsp_last_in   = 1'b1;
                  state_in      = S_IDLE;
               end
            end else begin
               state_in = S_LD_CMP;
            end
         end
         S_LD_CMP: begin
            if ((edge_rdata.src == ld_ff.src) && (edge_rdata.dst == ld_ff.dst)) begin
               if (rsp_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = KIND_REJECT;
                  rsp_vertex_in = '0;
                  rsp_dist_in   = '0;
                  rsp_reach_in  = 1'b0;
                  rsp_last_in   = 1'b1;
                  state_in      = S_IDLE;
               end
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_LD_SCAN;
            end
         end
         S_RUN_EDGE: begin
            if (idx_ff != count_ff) begin
               state_in = S_RUN_FETCH;
            end else if (!changed_ff) begin
               // Settled: list the distances
               count_in = '0;
               vtx_in   = 7'd1;
               state_in = S_OUT_READ;
            end else if (pass_ff == n_eff) begin
               // Check pass still changed something
               if (rsp_free) begin
                  count_in      = '0;
                  rsp_valid_in  = 1'b1;
                  rsp_kind_in   = KIND_NEGCYC;
                  rsp_vertex_in = '0;
                  rsp_dist_in   = '0;
                  rsp_reach_in  = 1'b0;
                  rsp_last_in   = 1'b1;
                  state_in      = S_IDLE;
               end
            end else begin
               pass_in    = pass_ff + 7'd1;
               changed_in = 1'b0;
               idx_in     = '0;
            end
         end
         S_RUN_FETCH: begin
            edge_in = edge_rdata;
            if (edge_use) begin
               state_in = S_RUN_SRC;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_RUN_EDGE;
            end
         end
         S_RUN_SRC: begin
            state_in = S_RUN_DST;
         end
         S_RUN_DST: begin
            // Relax the edge
            if (!ok_ff[VW'(edge_ff.dst - 7'd1)] || ($signed(dist_rdata) > $signed(sum_ff))) begin
               dist_we                          = 1'b1;
               ok_in[VW'(edge_ff.dst - 7'd1)]   = 1'b1;
               changed_in                       = 1'b1;
            end
            idx_in   = idx_ff + 1'b1;
            state_in = S_RUN_EDGE;
         end
         S_OUT_READ: begin
            if (vtx_ff == start_ff) begin
               vtx_in = vtx_ff + 7'd1;
            end else begin
               state_in = S_OUT_LOAD;
            end
         end
         S_OUT_LOAD: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_DIST;
               rsp_vertex_in = vtx_ff;
               rsp_reach_in  = ok_ff[VW'(vtx_ff - 7'd1)];
               rsp_dist_in   = ok_ff[VW'(vtx_ff - 7'd1)] ? dist_rdata : '0;
               rsp_last_in   = out_last;
               vtx_in        = vtx_ff + 7'd1;
               state_in      = out_last ? S_IDLE : S_OUT_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         nv_ff        <= NUM_VERTICES_RESET;
         count_ff     <= '0;
         ok_ff        <= '0;
         changed_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nv_ff        <= nv_in;
         count_ff     <= count_in;
         ok_ff        <= ok_in;
         changed_ff   <= changed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      pass_ff       <= pass_in;
      vtx_ff        <= vtx_in;
      func_ff       <= func_in;
      ld_ff         <= ld_in;
      start_ff      <= start_in;
      edge_ff       <= edge_in;
      sum_ff        <= sum_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_dist_ff   <= rsp_dist_in;
      rsp_reach_ff  <= rsp_reach_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Edge table
   bfsp_ram #(
      .WIDTH ($bits(edge_type)),
      .DEPTH (MAX_EDGES)
   ) u_edge_ram (
      .clock   (clock),
      .wr_en   (edge_we),
      .wr_addr (count_ff[EAW-1:0]),
      .wr_data (ld_ff),
      .rd_addr (idx_ff[EAW-1:0]),
      .rd_data (edge_rdata)
   );

   // Distance values; reachability lives in ok_ff
   bfsp_ram #(
      .WIDTH (DIST_W),
      .DEPTH (MAX_VERTICES)
   ) u_dist_ram (
      .clock   (clock),
      .wr_en   (dist_we),
      .wr_addr (dist_waddr),
      .wr_data (dist_wdata),
      .rd_addr (dist_raddr),
      .rd_data (dist_rdata)
   );

   // Ports
   assign req.ready     = (state_ff == S_IDLE);
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.kind      = rsp_kind_ff;
   assign rsp.vertex    = rsp_vertex_ff;
   assign rsp.distance  = rsp_dist_ff;
   assign rsp.reachable = rsp_reach_ff;
   assign rsp.last      = rsp_last_ff;

endmodule

// ===== src/bfsp_chk.sv =====
module bfsp_chk import bfsp_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [2:0]          rsp_kind,
   input logic [VERTEX_W-1:0] rsp_vertex,
   input logic [DIST_W-1:0]   rsp_distance,
   input logic                rsp_reachable,
   input logic                rsp_last
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_vertex)
                                  && $stable(rsp_distance) && $stable(rsp_last))
      else $error("stalled result changed");

   // One item at a time: no accept right after an accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted while busy");

   // A run still listing distances takes no new item
   a_no_accept_mid_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("input ready before run finished");

   // Only distance results carry a vertex; others are single and plain
   a_kind_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == KIND_DIST)
                    ? (rsp_vertex != '0 && (rsp_reachable || rsp_distance == '0))
                    : (rsp_vertex == '0 && rsp_distance == '0 && !rsp_reachable && rsp_last))
      else $error("result fields inconsistent with kind");

endmodule

bind bellman_ford_shortest_paths_core bfsp_chk u_bfsp_chk (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req.valid),
   .req_ready     (req.ready),
   .rsp_valid     (rsp.valid),
   .rsp_ready     (rsp.ready),
   .rsp_kind      (rsp.kind),
   .rsp_vertex    (rsp.vertex),
   .rsp_distance  (rsp.distance),
   .rsp_reachable (rsp.reachable),
   .rsp_last      (rsp.last)
);

// ===== test/bellman_ford_shortest_paths_core_test.sv =====
`timescale 1ns / 100ps

module bellman_ford_shortest_paths_core_test;
   import bfsp_pkg::*;

   localparam int WATCHDOG_LIMIT  = 200000;
   localparam int TAIL_CYCLES     = 64;
   localparam int MAX_REPORTS     = 10;
   localparam int ITEMS_PER_PHASE = 16;

   typedef struct packed {
      logic [2:0]          kind;
      logic [VERTEX_W-1:0] vertex;
      logic [DIST_W-1:0]   distance;
      logic                reachable;
      logic                last;
   } path_result_t;

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                csr_we    = 1'b0;
   logic [VERTEX_W-1:0] csr_wdata = '0;

   bfsp_req_if req_if ();
   bfsp_rsp_if rsp_if ();

   // Shadow copy of the edge table, distances and vertex count register
   logic [VERTEX_W-1:0]        edge_src [MAX_EDGES_DEF];
   logic [VERTEX_W-1:0]        edge_dst [MAX_EDGES_DEF];
   logic signed [WEIGHT_W-1:0] edge_wt  [MAX_EDGES_DEF];
   int                         stored_edges = 0;
   logic [VERTEX_W-1:0]        vertex_count_reg = NUM_VERTICES_RESET;
   logic signed [DIST_W-1:0]   path_dist    [1:MAX_VERTICES_DEF];
   bit                         path_reached [1:MAX_VERTICES_DEF];

   path_result_t pending_results [$];
   int           error_count  = 0;
   int           items_sent   = 0;
   int           quiet_cycles = 0;
   int           idle_pct     = 0;
   int           stall_pct    = 0;

   always #2 clock = ~clock;

   bellman_ford_shortest_paths_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Vertex count in force: register value clamped into 2..MAX_VERTICES
   function automatic int active_vertices();
      int n;
      n = vertex_count_reg;
      if (n < 2) n = 2;
      if (n > MAX_VERTICES_DEF) n = MAX_VERTICES_DEF;
      return n;
   endfunction

   function automatic void add_expected(logic [2:0] kind, int vertex,
                                        logic [DIST_W-1:0] dist_value, logic reach, logic last);
      path_result_t r;
      r.kind      = kind;
      r.vertex    = VERTEX_W'(vertex);
      r.distance  = dist_value;
      r.reachable = reach;
      r.last      = last;
      pending_results.push_back(r);
   endfunction

   // One pass over the edges in load order; skip edges with an endpoint outside 1..n or an unreached source
   function automatic bit relax_edges(int n);
      bit     changed;
      int     i;
      int     a;
      int     b;
      longint sum;
      changed = 1'b0;
      for (i = 0; i < stored_edges; i++) begin
         a = edge_src[i];
         b = edge_dst[i];
         if (a < 1 || a > n || b < 1 || b > n) continue;
         if (!path_reached[a]) continue;
         sum = longint'(path_dist[a]) + longint'(edge_wt[i]);
         if (sum > longint'($signed(INT_MAX))) sum = longint'($signed(INT_MAX));
         if (sum < longint'($signed(INT_MIN))) sum = longint'($signed(INT_MIN));
         if (!path_reached[b] || longint'(path_dist[b]) > sum) begin
            path_dist[b]    = sum[DIST_W-1:0];
            path_reached[b] = 1'b1;
            changed         = 1'b1;
         end
      end
      return changed;
   endfunction

   // Work out the results of one accepted item and queue them
   function automatic void predict_paths(logic func, logic [VERTEX_W-1:0] src,
                                         logic [VERTEX_W-1:0] dst, logic [WEIGHT_W-1:0] weight,
                                         logic [VERTEX_W-1:0] start);
      int n;
      int j;
      int v;
      bit ok;
      bit changed;
      n = active_vertices();
      if (func == FUNC_LOAD) begin
         ok = !(src == dst || src < 1 || dst < 1 || src > n || dst > n);
         if (ok && stored_edges >= MAX_EDGES_DEF) ok = 1'b0;
         for (j = 0; ok && j < stored_edges; j++) begin
            if (edge_src[j] == src && edge_dst[j] == dst) ok = 1'b0;
         end
         if (ok) begin
            edge_src[stored_edges] = src;
            edge_dst[stored_edges] = dst;
            edge_wt[stored_edges]  = weight;
            stored_edges++;
         end
         add_expected(ok ? KIND_ACCEPT : KIND_REJECT, 0, '0, 1'b0, 1'b1);
      end else if (start < 1 || start > n) begin
         add_expected(KIND_BADSTART, 0, '0, 1'b0, 1'b1);
      end else begin
         for (v = 1; v <= MAX_VERTICES_DEF; v++) begin
            path_reached[v] = 1'b0;
            path_dist[v]    = '0;
         end
         path_reached[start] = 1'b1;
         changed = 1'b0;
         for (j = 1; j < n; j++) begin
            changed = relax_edges(n);
            if (!changed) break;
         end
         if (changed) changed = relax_edges(n);
         stored_edges = 0;
         if (changed) begin
            add_expected(KIND_NEGCYC, 0, '0, 1'b0, 1'b1);
         end else begin
            for (v = 1; v <= n; v++) begin
               if (v == start) continue;
               add_expected(KIND_DIST, v, path_reached[v] ? path_dist[v] : '0,
                            path_reached[v], (v == n) || (v == n - 1 && start == n));
            end
         end
      end
   endfunction

   task automatic note_error(string what, path_result_t want, path_result_t got);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("%0t %s: expected kind %0d vertex %0d dist %0d reach %0b last %0b,",
                  $time, what, want.kind, want.vertex, $signed(want.distance),
                  want.reachable, want.last);
         $display("   got kind %0d vertex %0d dist %0d reach %0b last %0b",
                  got.kind, got.vertex, $signed(got.distance), got.reachable, got.last);
      end
   endtask

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin : check_results
      path_result_t got;
      path_result_t want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.kind      = rsp_if.kind;
         got.vertex    = rsp_if.vertex;
         got.distance  = rsp_if.distance;
         got.reachable = rsp_if.reachable;
         got.last      = rsp_if.last;
         if (pending_results.size() == 0) begin
            note_error("result with nothing expected", '0, got);
         end else begin
            want = pending_results.pop_front();
            if (got.kind !== want.kind || got.vertex !== want.vertex ||
                got.distance !== want.distance || got.reachable !== want.reachable ||
                got.last !== want.last) begin
               note_error("result mismatch", want, got);
            end
         end
      end
   end

   // Stall the result channel at random
   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
   end

   // End the run when nothing moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Present one item, hold it until accepted, then predict its results
   task automatic send_request(logic func, logic [VERTEX_W-1:0] src, logic [VERTEX_W-1:0] dst,
                               logic [WEIGHT_W-1:0] weight, logic [VERTEX_W-1:0] start);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.func         <= func;
      req_if.src_vertex   <= src;
      req_if.dst_vertex   <= dst;
      req_if.edge_weight  <= weight;
      req_if.start_vertex <= start;
      do @(posedge clock); while (!req_if.ready);
      items_sent++;
      predict_paths(func, src, dst, weight, start);
   endtask

   task automatic load_edge(int src, int dst, logic [WEIGHT_W-1:0] weight);
      send_request(FUNC_LOAD, VERTEX_W'(src), VERTEX_W'(dst), weight,
                   VERTEX_W'($urandom_range(127)));
   endtask

   task automatic run_from(int start);
      send_request(FUNC_RUN, VERTEX_W'($urandom_range(127)), VERTEX_W'($urandom_range(127)),
                   WEIGHT_W'($urandom), VERTEX_W'(start));
   endtask

   // Drop valid and wait until every expected result has come back
   task automatic wait_idle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic set_vertex_count(int value);
      wait_idle();
      csr_we           <= 1'b1;
      csr_wdata        <= VERTEX_W'(value);
      vertex_count_reg  = VERTEX_W'(value);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Reset count of 64: endpoint checks, duplicates, bad starts, weight extremes
   task automatic test_load_rules();
      load_edge(1, 2, 16'h7FFF);
      load_edge(2, 64, 16'h8000);
      load_edge(5, 5, 16'h0001);
      load_edge(0, 3, 16'h0000);
      load_edge(3, 127, 16'hFFFF);
      load_edge(65, 1, 16'h0010);
      load_edge(1, 2, 16'h0005);
      run_from(0);
      run_from(127);
      load_edge(64, 3, 16'hFFFF);
      run_from(1);
   endtask

   // Edges stored under a larger count are skipped after the count shrinks
   task automatic test_stale_edges();
      load_edge(1, 40, 16'd5);
      load_edge(2, 3, 16'd0);
      set_vertex_count(10);
      load_edge(1, 2, 16'd7);
      run_from(1);
   endtask

   task automatic test_negative_cycle();
      set_vertex_count(3);
      load_edge(1, 2, 16'd1);
      load_edge(2, 3, -16'sd5);
      load_edge(3, 2, 16'd2);
      run_from(1);
   endtask

   // Register values 0, 1 and 127 clamp to the smallest and largest counts
   task automatic test_count_clamp();
      set_vertex_count(0);
      load_edge(1, 2, 16'h8000);
      load_edge(2, 1, 16'd100);
      run_from(2);
      set_vertex_count(1);
      run_from(1);
      set_vertex_count(127);
      load_edge(64, 63, 16'd3);
      run_from(64);
   endtask

   // One random graph: set a count, load a few edges, usually run it
   task automatic random_graph();
      int                  value;
      int                  n;
      int                  edges;
      int                  k;
      int                  s;
      int                  d;
      logic [WEIGHT_W-1:0] w;
      case ($urandom_range(9))
         0:       value = $urandom_range(1);
         1:       value = $urandom_range(127, 65);
         2:       value = $urandom_range(64, 11);
         default: value = $urandom_range(10, 2);
      endcase
      set_vertex_count(value);
      n     = active_vertices();
      edges = $urandom_range(1, (n * (n - 1) < 12) ? n * (n - 1) : 12);
      for (k = 0; k < edges; k++) begin
         if ($urandom_range(9) == 0) begin
            s = $urandom_range(127);
            d = $urandom_range(127);
         end else begin
            s = $urandom_range(n, 1);
            d = $urandom_range(n, 1);
            if (d == s && $urandom_range(3) != 0) d = (s % n) + 1;
         end
         case ($urandom_range(3))
            0:       w = WEIGHT_W'($urandom);
            1:       w = WEIGHT_W'(0 - $urandom_range(20, 1));
            default: w = WEIGHT_W'($urandom_range(50));
         endcase
         load_edge(s, d, w);
      end
      if ($urandom_range(9) != 0) begin
         run_from(($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(n, 1));
      end
   endtask

   // Random graphs under each idle and stall pattern in turn
   task automatic test_random_graphs();
      int phase;
      int first_item;
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 78; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 78; end
            default: begin idle_pct = 22; stall_pct = 22; end
         endcase
         first_item = items_sent;
         while (items_sent - first_item < ITEMS_PER_PHASE) random_graph();
      end
   endtask

   initial begin
      req_if.valid        = 1'b0;
      req_if.func         = FUNC_LOAD;
      req_if.src_vertex   = '0;
      req_if.dst_vertex   = '0;
      req_if.edge_weight  = '0;
      req_if.start_vertex = '0;

      // Hold reset, then release it on a falling edge
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_load_rules();
      test_stale_edges();
      test_negative_cycle();
      test_count_clamp();
      test_random_graphs();

      // Drain, then watch a little longer for stray results
      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/bfsp_pkg.sv
src/bfsp_if.sv
src/bfsp_ram.sv
src/bellman_ford_shortest_paths_core.sv
src/bfsp_chk.sv
test/bellman_ford_shortest_paths_core_test.sv
